// ===== rtl/core/blpm_pkg.sv =====
// Shared types and constants of the binary trie longest prefix match core.
package blpm_pkg;

    // Address and prefix geometry
    localparam int ADDR_BITS = 32;
    localparam int LEN_W     = 6;

    // Operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Insert status codes
    localparam logic OUTCOME_DONE = 1'b0;
    localparam logic OUTCOME_FULL = 1'b1;

    typedef struct packed {
        logic                 operation;
        logic [ADDR_BITS-1:0] address;
        logic [LEN_W-1:0]     prefix_length;
        logic [ADDR_BITS-1:0] next_hop;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_BITS-1:0] hop_result;
        logic                 matched;
        logic                 outcome;
    } t_out_item;

endpackage

// ===== rtl/core/blpm_if.sv =====
// Valid/ready channel interfaces for the request and result streams.
interface blpm_in_if;
    import blpm_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface blpm_out_if;
    import blpm_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/binary_trie_longest_prefix_match_core.sv =====
// Top level: IPv4 longest prefix match over a binary trie held in a node pool.
// The core takes one request at a time: a lookup (operation 0) walks the trie
// one level per cycle, MSB of the address first, and returns the next hop of
// the deepest marked node on its path (root and depth-32 node included), or
// matched 0 and hop 0. An insert (operation 1) walks prefix_length bits
// (values above 32 act as 32), allocating missing nodes, and marks the last
// node with next_hop; if a node is needed while all POOL_NODES are in use it
// returns outcome 1 and stores nothing, keeping any nodes it already added.
// Each level walked is one read of the node memory. An insert visits each
// existing level once and spends two steps on each new node (link write,
// then the new node's clear). The request side is ready only between
// requests, again from the cycle the result appears; a finished result waits
// in an output register until taken, and a second finished result stalls the
// core until the first one is transferred.
// No clearing pass is needed after reset: only the root row is forced empty.
module binary_trie_longest_prefix_match_core #(
    parameter int POOL_NODES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    blpm_in_if.sink     i_in,
    blpm_out_if.source  o_out
);
    import blpm_pkg::*;

    localparam int NW = $clog2(POOL_NODES);
    localparam int PW = $clog2(POOL_NODES + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_INS  = 3'd2;
    localparam logic [2:0] S_NEW  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    typedef struct packed {
        logic          marked;
        logic [NW-1:0] one;
        logic [NW-1:0] zero;
    } t_row;

    // Node pool memories
    t_row                 mem_node [POOL_NODES];
    logic [ADDR_BITS-1:0] mem_hop  [POOL_NODES];

    logic [2:0]           r_state,   n_state;
    logic [ADDR_BITS-1:0] r_addr,    n_addr;
    logic [LEN_W-1:0]     r_plen,    n_plen;
    logic [ADDR_BITS-1:0] r_hop,     n_hop;
    logic [NW-1:0]        r_node,    n_node;
    logic [LEN_W-1:0]     r_depth,   n_depth;
    logic                 r_fresh,   n_fresh;
    logic                 r_root_ok, n_root_ok;
    logic [PW-1:0]        r_pool,    n_pool;
    logic [ADDR_BITS-1:0] r_best,    n_best;
    logic                 r_found,   n_found;
    logic                 r_fail,    n_fail;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out,     n_out;

    t_row                 r_row_rd;
    logic [ADDR_BITS-1:0] r_hop_rd;

    t_row                 w_row;
    logic                 w_bit;
    logic [NW-1:0]        w_child;
    logic [NW-1:0]        w_new;
    logic                 w_row_we;
    logic [NW-1:0]        w_row_wa;
    t_row                 w_row_wd;
    logic                 w_hop_we;

    // Effective row: fresh nodes and the unwritten root read as empty
    always_comb begin
        if (r_fresh || (r_node == '0 && !r_root_ok)) begin
            w_row = '0;
        end else begin
            w_row = r_row_rd;
        end
    end

    assign w_bit   = r_addr[ADDR_BITS-1];
    assign w_child = w_bit ? w_row.one : w_row.zero;
    assign w_new   = r_pool[NW-1:0];

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_plen      = r_plen;
        n_hop       = r_hop;
        n_node      = r_node;
        n_depth     = r_depth;
        n_fresh     = r_fresh;
        n_root_ok   = r_root_ok;
        n_pool      = r_pool;
        n_best      = r_best;
        n_found     = r_found;
        n_fail      = r_fail;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_row_we    = 1'b0;
        w_row_wa    = r_node;
        w_row_wd    = w_row;
        w_hop_we    = 1'b0;

        // Drop the held result once transferred
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_addr  = i_in.data.address;
                    n_hop   = i_in.data.next_hop;
                    n_plen  = (i_in.data.prefix_length > LEN_W'(ADDR_BITS)) ?
                              LEN_W'(ADDR_BITS) : i_in.data.prefix_length;
                    n_node  = '0;
                    n_depth = '0;
                    n_fresh = 1'b0;
                    n_best  = '0;
                    n_found = 1'b0;
                    n_fail  = 1'b0;
                    n_state = (i_in.data.operation == OP_INSERT) ? S_INS : S_LOOK;
                end
            end
            S_LOOK: begin
                // Keep the deepest marked hop, then step to the child
                if (w_row.marked) begin
                    n_best  = r_hop_rd;
                    n_found = 1'b1;
                end
                if (r_depth == LEN_W'(ADDR_BITS) || w_child == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_node  = w_child;
                    n_depth = r_depth + LEN_W'(1);
                    n_addr  = {r_addr[ADDR_BITS-2:0], 1'b0};
                end
            end
            S_INS: begin
                priority if (r_depth == r_plen) begin
                    // Mark the final node and store its hop
                    w_row_we        = 1'b1;
                    w_row_wd.marked = 1'b1;
                    w_hop_we        = 1'b1;
                    n_state         = S_DONE;
                end else if (w_child != '0) begin
                    n_node  = w_child;
                    n_depth = r_depth + LEN_W'(1);
                    n_addr  = {r_addr[ADDR_BITS-2:0], 1'b0};
                end else if (r_pool == PW'(POOL_NODES)) begin
                    n_fail  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    // Link the parent to the next free node
                    w_row_we = 1'b1;
                    if (w_bit) begin
                        w_row_wd.one = w_new;
                    end else begin
                        w_row_wd.zero = w_new;
                    end
                    n_state = S_NEW;
                end
            end
            S_NEW: begin
                // Clear the new node and descend into it
                w_row_we = 1'b1;
                w_row_wa = w_new;
                w_row_wd = '0;
                n_node   = w_new;
                n_pool   = r_pool + PW'(1);
                n_depth  = r_depth + LEN_W'(1);
                n_addr   = {r_addr[ADDR_BITS-2:0], 1'b0};
                n_fresh  = 1'b1;
                n_state  = S_INS;
            end
            S_DONE: begin
                // Hand the result to the output register when it is free
                if (!r_out_valid || o_out.ready) begin
                    n_out.hop_result = r_found ? r_best : '0;
                    n_out.matched    = r_found;
                    n_out.outcome    = r_fail ? OUTCOME_FULL : OUTCOME_DONE;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_row_we && w_row_wa == '0) begin
            n_root_ok = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_root_ok   <= 1'b0;
            r_pool      <= PW'(1);
            r_out_valid <= 1'b0;
            r_fresh     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_root_ok   <= n_root_ok;
            r_pool      <= n_pool;
            r_out_valid <= n_out_valid;
            r_fresh     <= n_fresh;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_plen  <= n_plen;
        r_hop   <= n_hop;
        r_node  <= n_node;
        r_depth <= n_depth;
        r_best  <= n_best;
        r_found <= n_found;
        r_fail  <= n_fail;
        r_out   <= n_out;
    end

    // Node memory: one write port, registered read of the next node
    always_ff @(posedge i_clk) begin
        if (w_row_we) begin
            mem_node[w_row_wa] <= w_row_wd;
        end
        r_row_rd <= mem_node[n_node];
    end

    // Hop memory
    always_ff @(posedge i_clk) begin
        if (w_hop_we) begin
            mem_hop[r_node] <= r_hop;
        end
        r_hop_rd <= mem_hop[n_node];
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Pool count stays between the root alone and a full pool
    a_pool_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pool != '0 && r_pool <= PW'(POOL_NODES))
        else $error("node pool count out of range");

    // Pool grows only while a new node is being set up
    a_pool_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_pool != $past(r_pool) |-> $past(r_state) == S_NEW)
        else $error("node pool count changed outside allocation");

    // A refused insert never reports a match
    a_full_nomatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.outcome == OUTCOME_FULL |-> !r_out.matched)
        else $error("full status together with a match");

    // Walk never goes past the last address bit
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOOK || r_state == S_INS |-> r_depth <= LEN_W'(ADDR_BITS))
        else $error("trie walk deeper than the address");

endmodule
